### rtl/fat_sector_chain_walker_macros.svh
`ifndef FAT_SECTOR_CHAIN_WALKER_MACROS_SVH
`define FAT_SECTOR_CHAIN_WALKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FSCW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fscw assertion failed");

// next-cycle implication
`define FSCW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fscw assertion failed");

`else

`define FSCW_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FSCW_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/fscw_pkg.sv
`timescale 1ns / 1ps

package fscw_pkg;

  localparam int SEC_W   = 10;
  localparam int IDX_W   = 10;
  localparam int WORD_W  = 32;
  localparam int ENT_W   = 11;
  localparam int EPOCH_W = 8;

  localparam logic [WORD_W-1:0] MK_FREE = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] MK_END  = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] MK_FAT  = 32'hFFFF_FFFD;
  localparam logic [WORD_W-1:0] MK_DIF  = 32'hFFFF_FFFC;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STAT_SECTOR  = 3'd0,
    STAT_END     = 3'd1,
    STAT_CYCLE   = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_MARKER  = 3'd4,
    STAT_WRITTEN = 3'd5,
    STAT_IDLE    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    status_t          status;
    logic             done;
  } res_t;

endpackage

### rtl/fat_sector_chain_walker.sv
`timescale 1ns / 1ps
// FAT sector chain walker. A write transaction stores one table word and a start transaction
// opens a chain; each answers in the cycle after acceptance. An advance that follows a link
// reads the table and the visited map in one synchronous RAM access, so its result is
// registered after the ST_READ state, and one transaction is in progress at a time. Visited
// marks are epoch stamps, so a start clears the map at once; after reset, and again on every
// 255th start, the block sweeps every entry of the visited RAM with in_ready low
// (configuration writes are still taken). Reading a table entry that was never written gives
// an undefined result.

module fat_sector_chain_walker
  import fscw_pkg::*;
#(
  parameter int FAT_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [9:0]  in_entry_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_sector,
  output logic [2:0]  out_status,
  output logic        out_done_res
);

  localparam int AW = $clog2(FAT_DEPTH);

  res_t                out_res;
  logic                fat_we;
  logic [AW-1:0]       fat_addr;
  logic [WORD_W-1:0]   fat_wdata;
  logic [WORD_W-1:0]   fat_rdata;
  logic                vis_we;
  logic [AW-1:0]       vis_addr;
  logic [EPOCH_W-1:0]  vis_wdata;
  logic [EPOCH_W-1:0]  vis_rdata;

  fscw_walk_ctrl #(
    .FAT_DEPTH (FAT_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (out_res),
    .fat_we         (fat_we),
    .fat_addr       (fat_addr),
    .fat_wdata      (fat_wdata),
    .fat_rdata      (fat_rdata),
    .vis_we         (vis_we),
    .vis_addr       (vis_addr),
    .vis_wdata      (vis_wdata),
    .vis_rdata      (vis_rdata)
  );

  fscw_ram #(
    .DEPTH (FAT_DEPTH),
    .DW    (WORD_W)
  ) u_fat_ram (
    .clk   (clk),
    .we    (fat_we),
    .addr  (fat_addr),
    .wdata (fat_wdata),
    .rdata (fat_rdata)
  );

  fscw_ram #(
    .DEPTH (FAT_DEPTH),
    .DW    (EPOCH_W)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .addr  (vis_addr),
    .wdata (vis_wdata),
    .rdata (vis_rdata)
  );

  assign out_sector   = out_res.sector;
  assign out_status   = out_res.status;
  assign out_done_res = out_res.done;

endmodule

### rtl/fscw_ram.sv
`timescale 1ns / 1ps

module fscw_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/fscw_walk_ctrl.sv
`timescale 1ns / 1ps
`include "fat_sector_chain_walker_macros.svh"

module fscw_walk_ctrl
  import fscw_pkg::*;
#(
  parameter int FAT_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ENT_W-1:0]             cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [IDX_W-1:0]             in_entry_index,
  input  logic [WORD_W-1:0]            in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output res_t                         out_res,
  output logic                         fat_we,
  output logic [$clog2(FAT_DEPTH)-1:0] fat_addr,
  output logic [WORD_W-1:0]            fat_wdata,
  input  logic [WORD_W-1:0]            fat_rdata,
  output logic                         vis_we,
  output logic [$clog2(FAT_DEPTH)-1:0] vis_addr,
  output logic [EPOCH_W-1:0]           vis_wdata,
  input  logic [EPOCH_W-1:0]           vis_rdata
);

  localparam int AW = $clog2(FAT_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FAT_DEPTH - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [WORD_W-1:0]   cur_sec_r, cur_sec_nxt;
  logic                walking_r, walking_nxt;
  logic [ENT_W-1:0]    lim_r, lim_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;

  logic                in_fire;
  logic                idx_ok;
  logic                start_empty;
  logic                adv_go;
  logic                is_cycle;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign idx_ok      = 32'(in_entry_index) < 32'(FAT_DEPTH);
  assign start_empty = (in_value == MK_END) || (in_value == MK_FREE);
  assign adv_go      = walking_r && (cur_sec_r != MK_END) && (cur_sec_r >= 32'(lim_r)) == 1'b0;
  assign is_cycle    = (vis_rdata == epoch_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_START && epoch_r == EPOCH_MAX) begin
            state_nxt = ST_SWEEP;
          end else if (in_op == OP_ADVANCE && adv_go) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    epoch_nxt     = epoch_r;
    cur_sec_nxt   = cur_sec_r;
    walking_nxt   = walking_r;
    lim_nxt       = lim_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    fat_we        = 1'b0;
    fat_addr      = AW'(cur_sec_r);
    fat_wdata     = in_value;
    vis_we        = 1'b0;
    vis_addr      = AW'(cur_sec_r);
    vis_wdata     = epoch_r;

    if (cfg_wr_en) begin
      lim_nxt = (32'(cfg_wr_data) > 32'(FAT_DEPTH)) ? ENT_W'(FAT_DEPTH) : cfg_wr_data;
    end

    case (state_r)
      ST_SWEEP: begin
        vis_we        = 1'b1;
        vis_addr      = sweep_cnt_r;
        vis_wdata     = '0;
        sweep_cnt_nxt = (sweep_cnt_r == LAST_ADDR) ? '0 : sweep_cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{sector: '0, status: STAT_IDLE, done: 1'b0};
          case (in_op)
            OP_WRITE: begin
              fat_we      = idx_ok;
              fat_addr    = AW'(in_entry_index);
              out_res_nxt = '{sector: '0, status: STAT_WRITTEN, done: 1'b0};
            end
            OP_START: begin
              epoch_nxt = (epoch_r == EPOCH_MAX) ? EPOCH_FIRST : epoch_r + EPOCH_FIRST;
              if (start_empty) begin
                walking_nxt = 1'b0;
                cur_sec_nxt = '0;
                out_res_nxt = '{sector: '0, status: STAT_END, done: 1'b1};
              end else begin
                walking_nxt = 1'b1;
                cur_sec_nxt = in_value;
              end
            end
            OP_ADVANCE: begin
              if (walking_r) begin
                if (cur_sec_r == MK_END) begin
                  walking_nxt = 1'b0;
                  out_res_nxt = '{sector: '0, status: STAT_END, done: 1'b1};
                end else if (cur_sec_r >= 32'(lim_r)) begin
                  walking_nxt = 1'b0;
                  out_res_nxt = '{sector: '0, status: STAT_RANGE, done: 1'b1};
                end else begin
                  out_valid_nxt = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        if (is_cycle) begin
          walking_nxt = 1'b0;
          out_res_nxt = '{sector: '0, status: STAT_CYCLE, done: 1'b1};
        end else begin
          vis_we = 1'b1;
          if (fat_rdata == MK_FAT || fat_rdata == MK_DIF) begin
            walking_nxt = 1'b0;
            out_res_nxt = '{sector: cur_sec_r[SEC_W-1:0], status: STAT_MARKER, done: 1'b1};
          end else begin
            cur_sec_nxt = fat_rdata;
            out_res_nxt = '{sector: cur_sec_r[SEC_W-1:0], status: STAT_SECTOR, done: 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      epoch_r     <= EPOCH_FIRST;
      cur_sec_r   <= '0;
      walking_r   <= 1'b0;
      lim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      epoch_r     <= epoch_nxt;
      cur_sec_r   <= cur_sec_nxt;
      walking_r   <= walking_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `FSCW_ASSERT_IMP(a_read_out_free, clk, rst_n, state_r == ST_READ, !out_valid_r)
  `FSCW_ASSERT_NXT(a_read_gives_result, clk, rst_n, state_r == ST_READ, out_valid_r)
  `FSCW_ASSERT_IMP(a_epoch_nonzero, clk, rst_n, 1'b1, epoch_r != '0)
  `FSCW_ASSERT_IMP(a_walk_end_reported, clk, rst_n, $past(rst_n) && $fell(walking_r), out_valid_r)

endmodule

### dv/fat_sector_chain_walker_checker.sv
`timescale 1ns / 1ps

module fat_sector_chain_walker_checker
  import fscw_pkg::*;
#(
  parameter int FAT_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ENT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [WORD_W-1:0] in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [SEC_W-1:0]  out_sector,
  input  logic [2:0]        out_status,
  input  logic              out_done_res,
  output int                outstanding,
  output int                errors
);

  logic [WORD_W-1:0]    fat_copy [FAT_DEPTH];
  logic [FAT_DEPTH-1:0] seen;
  logic [WORD_W-1:0]    cur_sector;
  logic                 walk_on;
  logic [ENT_W-1:0]     entries;
  res_t                 answers_due [$];
  int                   fails = 0;

  assign errors = fails;

  function automatic res_t chain_answer(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic [WORD_W-1:0] val);
    res_t              r;
    logic [WORD_W-1:0] lim;
    logic [WORD_W-1:0] nxt;
    r = '{sector: '0, status: STAT_IDLE, done: 1'b0};
    lim = WORD_W'(entries);
    if (lim > FAT_DEPTH) lim = WORD_W'(FAT_DEPTH);
    case (op)
      OP_WRITE: begin
        if (idx < FAT_DEPTH) fat_copy[idx] = val;
        r.status = STAT_WRITTEN;
      end
      OP_START: begin
        seen = '0;
        if (val == MK_END || val == MK_FREE) begin
          walk_on = 1'b0;
          cur_sector = '0;
          r.status = STAT_END;
          r.done = 1'b1;
        end else begin
          cur_sector = val;
          walk_on = 1'b1;
        end
      end
      OP_ADVANCE: begin
        if (walk_on) begin
          if (cur_sector == MK_END) begin
            walk_on = 1'b0;
            r.status = STAT_END;
            r.done = 1'b1;
          end else if (cur_sector >= lim) begin
            walk_on = 1'b0;
            r.status = STAT_RANGE;
            r.done = 1'b1;
          end else if (seen[cur_sector]) begin
            walk_on = 1'b0;
            r.status = STAT_CYCLE;
            r.done = 1'b1;
          end else begin
            seen[cur_sector] = 1'b1;
            nxt = fat_copy[cur_sector];
            r.sector = cur_sector[SEC_W-1:0];
            if (nxt == MK_FAT || nxt == MK_DIF) begin
              walk_on = 1'b0;
              r.status = STAT_MARKER;
              r.done = 1'b1;
            end else begin
              cur_sector = nxt;
              r.status = STAT_SECTOR;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t due;
    if (!rst_n) begin
      seen = '0;
      cur_sector = '0;
      walk_on = 1'b0;
      entries = '0;
      answers_due.delete();
    end else begin
      if (cfg_wr_en) entries = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: sector %0d status %0d done_res %0d",
                 out_sector, out_status, out_done_res);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (out_sector !== want.sector) begin
            $error("sector expected %0d actual %0d", want.sector, out_sector);
            fails++;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            fails++;
          end
          if (out_done_res !== want.done) begin
            $error("done_res expected %0d actual %0d", want.done, out_done_res);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        due = chain_answer(in_op, in_entry_index, in_value);
        answers_due = {answers_due, due};
      end
    end
    outstanding <= answers_due.size();
  end

endmodule

### dv/tb_fat_sector_chain_walker.sv
`timescale 1ns / 1ps

module tb_fat_sector_chain_walker;
  import fscw_pkg::*;

  localparam int         DEPTH     = 1024;
  localparam int         FILL      = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [9:0]  in_entry_index;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_sector;
  logic [2:0]  out_status;
  logic        out_done_res;
  logic        calm;
  int          outstanding;
  int          errors;

  fat_sector_chain_walker #(
    .FAT_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_entry_index(in_entry_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sector(out_sector),
    .out_status(out_status),
    .out_done_res(out_done_res)
  );

  fat_sector_chain_walker_checker #(
    .FAT_DEPTH(DEPTH)
  ) chain_chk (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_entry_index(in_entry_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sector(out_sector),
    .out_status(out_status),
    .out_done_res(out_done_res),
    .outstanding(outstanding),
    .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 14);
  end

  // links stay inside the filled entries, on a marker, or beyond any limit
  function automatic logic [31:0] random_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return $urandom_range(0, FILL - 1);
    if (r < 76) return MK_END;
    if (r < 81) return MK_FREE;
    if (r < 85) return MK_FAT;
    if (r < 89) return MK_DIF;
    return $urandom_range(32'hFFFF_FFFF, 2 * DEPTH);
  endfunction

  task automatic send(input logic [1:0] op, input logic [9:0] idx, input logic [31:0] val);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_entry_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_entries(input logic [10:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_walks(input int n, input int span);
    int sent;
    int pick;
    int steps;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 9) == 0)
          send(OP_START, 10'($urandom_range(0, DEPTH - 1)),
               $urandom_range(32'hFFFF_FFFF, 2 * DEPTH));
        else
          send(OP_START, 10'($urandom_range(0, DEPTH - 1)), $urandom_range(0, span));
        sent++;
        steps = $urandom_range(1, 14);
        repeat (steps) begin
          if ($urandom_range(0, 99) < 8) begin
            send(OP_WRITE, 10'($urandom_range(0, DEPTH - 1)), random_link());
            sent++;
          end
          send(OP_ADVANCE, 10'($urandom_range(0, DEPTH - 1)), $urandom);
          sent++;
        end
      end else if (pick < 82) begin
        send(OP_WRITE, 10'($urandom_range(0, DEPTH - 1)), random_link());
        sent++;
      end else if (pick < 90) begin
        send(OP_ADVANCE, 10'($urandom_range(0, DEPTH - 1)), $urandom);
        sent++;
      end else if (pick < 95) begin
        send(OP_UNUSED, 10'($urandom_range(0, DEPTH - 1)), $urandom);
        sent++;
      end else begin
        send(OP_START, 10'($urandom_range(0, DEPTH - 1)), MK_FREE - $urandom_range(0, 3));
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    int mid;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_WRITE;
    in_entry_index <= '0;
    in_value <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    out_ready <= 1'b0;
    calm <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: nothing can be read, an advance during a walk is out of range
    set_entries(11'd0);
    send(OP_ADVANCE, 10'd0, 32'd0);
    send(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF);
    send(OP_START, 10'd0, MK_END);
    send(OP_START, 10'd0, MK_FREE);
    send(OP_START, 10'd0, 32'd5);
    send(OP_ADVANCE, 10'd0, 32'd0);
    send(OP_ADVANCE, 10'd0, 32'd0);

    // fill the low entries; every start and link stays on a written entry, on a marker or out of range
    for (i = 0; i < FILL; i++) send(OP_WRITE, i[9:0], random_link());

    send(OP_WRITE, 10'd0, 32'd1);
    send(OP_WRITE, 10'd1, 32'd2);
    send(OP_WRITE, 10'd2, MK_END);
    send(OP_WRITE, 10'd3, 32'd4);
    send(OP_WRITE, 10'd4, 32'd3);
    send(OP_WRITE, 10'd5, MK_FAT);
    send(OP_WRITE, 10'd6, MK_DIF);
    send(OP_WRITE, 10'd7, MK_FREE);
    send(OP_WRITE, 10'd1023, MK_FREE);
    set_entries(11'd1024);

    // chain ending normally
    send(OP_START, 10'd0, 32'd0);
    repeat (5) send(OP_ADVANCE, 10'd0, 32'd0);
    // two-sector loop
    send(OP_START, 10'd0, 32'd3);
    repeat (3) send(OP_ADVANCE, 10'd0, 32'd0);
    // fat and difat marker links
    send(OP_START, 10'd0, 32'd5);
    send(OP_ADVANCE, 10'd0, 32'd0);
    send(OP_START, 10'd0, 32'd6);
    send(OP_ADVANCE, 10'd0, 32'd0);
    // free link followed into out of range
    send(OP_START, 10'd0, 32'd7);
    repeat (2) send(OP_ADVANCE, 10'd0, 32'd0);
    // top sector with a write in the middle of the walk
    send(OP_START, 10'd0, 32'd1023);
    send(OP_WRITE, 10'd9, 32'd0);
    repeat (2) send(OP_ADVANCE, 10'd0, 32'd0);
    send(OP_START, 10'd0, 32'h8000_0000);
    send(OP_ADVANCE, 10'd0, 32'd0);
    send(OP_START, 10'd0, MK_FAT);
    send(OP_ADVANCE, 10'd0, 32'd0);

    run_walks(110, FILL - 1);

    set_entries(11'd2047);
    calm <= 1'b1;
    run_walks(110, FILL - 1);
    calm <= 1'b0;

    mid = $urandom_range(2, FILL - 1);
    set_entries(mid[10:0]);
    run_walks(100, mid);

    set_entries(11'd1);
    run_walks(70, 1);

    mid = $urandom_range(DEPTH + 1, 2046);
    set_entries(mid[10:0]);
    run_walks(110, FILL - 1);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/fscw_pkg.sv
rtl/fscw_ram.sv
rtl/fscw_walk_ctrl.sv
rtl/fat_sector_chain_walker.sv
dv/fat_sector_chain_walker_checker.sv
dv/tb_fat_sector_chain_walker.sv
